// ===== src/hs_pkg.sv =====
package hs_pkg;

    // Element width is fixed by the item format
    localparam int DATA_WIDTH = 32;
    localparam int MAX_ELEMENTS_DEF = 64;

    typedef logic signed [DATA_WIDTH-1:0] data_t;

    // One input item
    typedef struct packed {
        data_t value;
        logic  final_item;
    } in_item_t;

    // One result item
    typedef struct packed {
        data_t sorted_value;
        logic  final_result;
    } out_item_t;

    // Occupied flag and element, as held in a cell or passed along the chain
    typedef struct packed {
        logic  vld;
        data_t data;
    } slot_t;

    // Control state of the sorter
    typedef enum logic [2:0] {
        ST_LOAD  = 3'b001,
        ST_DRAIN = 3'b010,
        ST_EMIT  = 3'b100
    } state_t;

endpackage

// ===== src/hs_cell.sv =====
module hs_cell (
    input  logic          clk,
    input  logic          rst_n,
    input  hs_pkg::slot_t ins,
    input  logic          shift,
    input  hs_pkg::slot_t right,
    output hs_pkg::slot_t own,
    output hs_pkg::slot_t pass
);

    logic          vld_reg;
    logic          vld_next;
    hs_pkg::data_t data_reg;
    hs_pkg::data_t data_next;
    logic          pass_vld_reg;
    logic          pass_vld_next;
    hs_pkg::data_t pass_data_reg;
    hs_pkg::data_t pass_data_next;

    // Keep the smaller element, hand the larger one on; shift left on emit
    always_comb
    begin
        vld_next       = vld_reg;
        data_next      = data_reg;
        pass_vld_next  = 1'b0;
        pass_data_next = ins.data;
        if (shift)
        begin
            vld_next  = right.vld;
            data_next = right.data;
        end
        else if (ins.vld)
        begin
            if (!vld_reg)
            begin
                vld_next  = 1'b1;
                data_next = ins.data;
            end
            else if (ins.data < data_reg)
            begin
                data_next      = ins.data;
                pass_vld_next  = 1'b1;
                pass_data_next = data_reg;
            end
            else
            begin
                pass_vld_next = 1'b1;
            end
        end
    end

    // Control flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= 1'b0;
            pass_vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg      <= vld_next;
            pass_vld_reg <= pass_vld_next;
        end
    end

    // Element payload
    always_ff @(posedge clk)
    begin
        data_reg      <= data_next;
        pass_data_reg <= pass_data_next;
    end

    assign own.vld   = vld_reg;
    assign own.data  = data_reg;
    assign pass.vld  = pass_vld_reg;
    assign pass.data = pass_data_reg;

endmodule

// ===== src/heap_sorter.sv =====
// Sorting chain: one cell per element, smallest element kept nearest the output.
// Loading takes one item per cycle; no result until the set is complete.
// After the last item the chain settles in the drain state, then emits n results, one per
// cycle while the output is not stalled; input is stalled from the last item until
// the final result has left the chain.
// Reset (rst_n, asynchronous, active low) empties all cells and returns to loading.
module heap_sorter #(
    parameter int MAX_ELEMENTS = hs_pkg::MAX_ELEMENTS_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  hs_pkg::in_item_t  item,
    output logic              result_valid,
    input  logic              result_stall,
    output hs_pkg::out_item_t result
);

    localparam int CW = $clog2(MAX_ELEMENTS + 1);
    localparam logic [CW-1:0] CNT_ONE = CW'(1);
    localparam logic [CW-1:0] CNT_MAX = CW'(MAX_ELEMENTS);

    hs_pkg::state_t    state_reg, state_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [CW-1:0]     drain_reg, drain_next;
    logic              out_vld_reg, out_vld_next;
    hs_pkg::out_item_t out_reg, out_next;

    logic          accept;
    logic          take;
    logic          shift;
    logic [CW-1:0] cnt_inc;

    hs_pkg::slot_t pass_w [MAX_ELEMENTS+1];
    hs_pkg::slot_t own_w  [MAX_ELEMENTS+1];

    assign item_stall = (state_reg != hs_pkg::ST_LOAD);
    assign accept     = item_valid && !item_stall;
    assign take       = !out_vld_reg || !result_stall;
    assign cnt_inc    = cnt_reg + CNT_ONE;
    assign shift      = (state_reg == hs_pkg::ST_EMIT) && take;

    // Feed the chain head with the accepted item; nothing enters past the tail
    assign pass_w[0].vld          = accept;
    assign pass_w[0].data         = item.value;
    assign own_w[MAX_ELEMENTS]    = '0;

    // Row of cells
    for (genvar i = 0; i < MAX_ELEMENTS; i++)
    begin : g_cell
        hs_cell u_cell (
            .clk   (clk),
            .rst_n (rst_n),
            .ins   (pass_w[i]),
            .shift (shift),
            .right (own_w[i+1]),
            .own   (own_w[i]),
            .pass  (pass_w[i+1])
        );
    end

    // Sequence loading, settling and emitting
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        drain_next   = drain_reg;
        out_vld_next = out_vld_reg;
        out_next     = out_reg;
        if (out_vld_reg && !result_stall)
        begin
            out_vld_next = 1'b0;
        end
        unique case (state_reg)
            hs_pkg::ST_LOAD:
            begin
                if (accept)
                begin
                    cnt_next = cnt_inc;
                    if (item.final_item || (cnt_inc == CNT_MAX))
                    begin
                        drain_next = cnt_inc;
                        state_next = hs_pkg::ST_DRAIN;
                    end
                end
            end
            hs_pkg::ST_DRAIN:
            begin
                drain_next = drain_reg - CNT_ONE;
                if (drain_reg <= CNT_ONE)
                begin
                    state_next = hs_pkg::ST_EMIT;
                end
            end
            hs_pkg::ST_EMIT:
            begin
                if (take)
                begin
                    out_vld_next          = 1'b1;
                    out_next.sorted_value = own_w[0].data;
                    out_next.final_result = (cnt_reg == CNT_ONE);
                    cnt_next              = cnt_reg - CNT_ONE;
                    if (cnt_reg == CNT_ONE)
                    begin
                        state_next = hs_pkg::ST_LOAD;
                    end
                end
            end
            default:
            begin
                state_next = hs_pkg::ST_LOAD;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= hs_pkg::ST_LOAD;
            cnt_reg     <= '0;
            drain_reg   <= '0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            drain_reg   <= drain_next;
            out_vld_reg <= out_vld_next;
        end
    end

    // Output item register
    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign result_valid = out_vld_reg;
    assign result       = out_reg;

endmodule
